// ----- rtl/wsd_pkg.sv -----
// websocket deframer shared package: result item type and header constants
// no dependencies; imported by every module of the deframer
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned LEN_W    = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned M_DATA_W = 32;

  localparam logic [6:0]         LEN_CODE_16     = 7'd126;
  localparam logic [6:0]         LEN_CODE_64     = 7'd127;
  localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RST = 16'd1024;

  // one result item
  typedef struct packed {
    logic                has_byte;
    logic [BYTE_W-1:0]   payload_byte;
    logic                frame_end;
    logic [OPCODE_W-1:0] frame_opcode;
    logic [COUNT_W-1:0]  kept_count;
  } res_t;

endpackage

// ----- rtl/wsd_parse.sv -----
// websocket deframer header/payload parser: frame state and single-pass next-state logic
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [wsd_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [wsd_pkg::COUNT_W-1:0]   max_payload,
  output logic                          res_valid,
  output wsd_pkg::res_t                 res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_H0,
    PH_H1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t              phase, phase_next;
  logic [OPCODE_W-1:0] cur_opcode, cur_opcode_next;
  logic                is_masked, is_masked_next;
  logic [2:0]          ext_count, ext_count_next;
  logic [LEN_W-1:0]    frame_length, frame_length_next;
  logic [KEY_W-1:0]    mask_key, mask_key_next;
  logic [LEN_W-1:0]    byte_index, byte_index_next;
  logic [COUNT_W-1:0]  kept_bytes, kept_bytes_next;

  logic [6:0]          len7;
  logic [LEN_W-1:0]    len_shift;
  logic                keep;
  logic [BYTE_W-1:0]   key_byte;

  assign len7      = rx_byte[6:0];
  assign len_shift = {frame_length[LEN_W-BYTE_W-1:0], rx_byte};
  assign keep      = byte_index < {{(LEN_W-COUNT_W){1'b0}}, max_payload};

  always_comb begin
    case (byte_index[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next        = phase;
    cur_opcode_next   = cur_opcode;
    is_masked_next    = is_masked;
    ext_count_next    = ext_count;
    frame_length_next = frame_length;
    mask_key_next     = mask_key;
    byte_index_next   = byte_index;
    kept_bytes_next   = kept_bytes;
    res_valid         = 1'b0;
    res.has_byte      = 1'b0;
    res.payload_byte  = '0;
    res.frame_end     = 1'b0;

    case (phase)
      PH_H0: begin
        cur_opcode_next = rx_byte[OPCODE_W-1:0];
        mask_key_next   = '0;
        phase_next      = PH_H1;
      end
      PH_H1: begin
        is_masked_next    = rx_byte[7];
        frame_length_next = '0;
        if (len7 == LEN_CODE_16) begin
          ext_count_next = 3'd1;
          phase_next     = PH_EXT;
        end else if (len7 == LEN_CODE_64) begin
          ext_count_next = 3'd7;
          phase_next     = PH_EXT;
        end else begin
          frame_length_next = {{(LEN_W-7){1'b0}}, len7};
          if (rx_byte[7]) begin
            ext_count_next = 3'd3;
            phase_next     = PH_KEY;
          end else begin
            byte_index_next = '0;
            kept_bytes_next = '0;
            if (len7 == 7'd0) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              phase_next    = PH_H0;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
      PH_EXT: begin
        frame_length_next = len_shift;
        if (ext_count == 3'd0) begin
          if (is_masked) begin
            ext_count_next = 3'd3;
            phase_next     = PH_KEY;
          end else begin
            byte_index_next = '0;
            kept_bytes_next = '0;
            if (len_shift == '0) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              phase_next    = PH_H0;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end else begin
          ext_count_next = ext_count - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[KEY_W-BYTE_W-1:0], rx_byte};
        if (ext_count == 3'd0) begin
          byte_index_next = '0;
          kept_bytes_next = '0;
          if (frame_length == '0) begin
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
            phase_next    = PH_H0;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          ext_count_next = ext_count - 3'd1;
        end
      end
      PH_DATA: begin
        byte_index_next = byte_index + 64'd1;
        res.frame_end   = (byte_index_next == frame_length);
        if (keep) begin
          res.has_byte     = 1'b1;
          res.payload_byte = rx_byte ^ key_byte;
          kept_bytes_next  = kept_bytes + 16'd1;
        end
        if (res.frame_end) begin
          phase_next = PH_H0;
        end
        res_valid = keep || res.frame_end;
      end
      default: begin
        phase_next = PH_H0;
      end
    endcase

    // opcode and count seen by the result are the values after this byte
    res.frame_opcode = cur_opcode;
    res.kept_count   = kept_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_H0;
      cur_opcode   <= '0;
      is_masked    <= 1'b0;
      ext_count    <= '0;
      frame_length <= '0;
      mask_key     <= '0;
      byte_index   <= '0;
      kept_bytes   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      cur_opcode   <= cur_opcode_next;
      is_masked    <= is_masked_next;
      ext_count    <= ext_count_next;
      frame_length <= frame_length_next;
      mask_key     <= mask_key_next;
      byte_index   <= byte_index_next;
      kept_bytes   <= kept_bytes_next;
    end
  end

endmodule

// ----- rtl/wsd_out_reg.sv -----
// websocket deframer result register: holds one result item for the downstream handshake
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  wsd_pkg::res_t res_in,
  input  logic          take,
  output logic          room,
  output logic          valid,
  output wsd_pkg::res_t res_out
);
  import wsd_pkg::*;

  // free if empty or being drained this cycle
  assign room = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// an accepted byte is parsed once the result register has room, which then holds its result (if any)
// throughput: one byte per cycle, sustained while the result side keeps up
// the input register and the result register each hold one item; the parser steps when
// the input register is full and the result register has room
// reset (rst, synchronous, active high): parser back to expecting a first header byte,
// max_payload back to 1024, both registers emptied
`timescale 1ns / 1ps

module websocket_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  // config write channel: max_payload
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsd_pkg::COUNT_W-1:0]   cfg_data,
  // received byte stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wsd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  // parsed results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wsd_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                                   // [27:12] kept_count, [31:28] zero
  output logic                          m_tuser,   // has_byte
  output logic                          m_tlast    // frame_end
);
  import wsd_pkg::*;

  logic [COUNT_W-1:0] max_payload;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  logic  step;
  logic  out_room;
  logic  res_valid;
  res_t  res;
  res_t  res_q;

  // config is always taken; the user must change it only while the block is idle (not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      max_payload <= cfg_data;
    end
  end

  // parser consumes the held byte whenever the result slot can take what it makes
  assign step     = in_valid && out_room;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  wsd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (in_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && res_valid),
    .res_in  (res),
    .take    (m_tready),
    .room    (out_room),
    .valid   (m_tvalid),
    .res_out (res_q)
  );

  assign m_tdata = {4'd0, res_q.kept_count, res_q.frame_opcode, res_q.payload_byte};
  assign m_tuser = res_q.has_byte;
  assign m_tlast = res_q.frame_end;

  // a result without a payload byte only ever closes a frame
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("result with no byte does not end a frame");

  // drained or empty-frame results carry a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
    else $error("non-data result carries a payload byte");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // nothing new is taken while the held byte is stuck behind a full result register
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while parser is stalled");

endmodule

// ----- dv/tb_websocket_frame_deframer.sv -----
// self-checking testbench for websocket_frame_deframer: frames go in byte by byte and
// every result item is checked against a parser model kept inside this bench
// depends on rtl/wsd_pkg.sv and rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // websocket opcodes used by name in the directed frames
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // drained bytes give no result item, so allow a margin before calling the block idle
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [2:0] {
    WAIT_OPCODE,
    WAIT_LEN,
    EXT_LEN,
    MASK_KEY,
    PAYLOAD
  } parse_phase_t;

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_enc_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  websocket_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state, at its reset values
  parse_phase_t         ph        = WAIT_OPCODE;
  logic [3:0]           cur_op    = '0;
  logic                 masked    = 1'b0;
  logic [2:0]           ext_left  = '0;
  logic [LEN_W-1:0]     frame_len = '0;
  logic [KEY_W-1:0]     key       = '0;
  logic [LEN_W-1:0]     pay_idx   = '0;
  logic [COUNT_W-1:0]   kept      = '0;
  logic [COUNT_W-1:0]   max_pay   = MAX_PAYLOAD_RST;

  res_t expected_results[$];

  // bench control and bookkeeping
  bit idle_on    = 1'b1;
  int hold_req   = 0;
  int hold_left  = 0;
  int stall_left = 0;
  int errors     = 0;
  int n_bytes    = 0;
  int n_frames   = 0;
  int n_results  = 0;
  int n_cfg      = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic void queue_result(input logic has, input logic [7:0] val,
                                       input logic fin);
    res_t r;
    r.has_byte     = has;
    r.payload_byte = val;
    r.frame_end    = fin;
    r.frame_opcode = cur_op;
    r.kept_count   = kept;
    expected_results.push_back(r);
  endfunction

  // header finished: a zero-length frame closes right here
  function automatic void header_complete();
    pay_idx = '0;
    kept    = '0;
    if (frame_len == '0) begin
      queue_result(1'b0, 8'h00, 1'b1);
      ph = WAIT_OPCODE;
    end else begin
      ph = PAYLOAD;
    end
  endfunction

  // length known: a masked frame still has four key bytes to come
  function automatic void length_known();
    if (masked) begin
      ext_left = 3'd3;
      ph = MASK_KEY;
    end else begin
      header_complete();
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [6:0]       len7;
    logic [LEN_W-1:0] idx;
    logic             keep;
    logic             last;
    logic [7:0]       key_b;
    logic [7:0]       val;
    case (ph)
      WAIT_OPCODE: begin
        // fin and rsv bits are don't-care
        cur_op = b[3:0];
        key    = '0;
        ph     = WAIT_LEN;
      end
      WAIT_LEN: begin
        len7      = b[6:0];
        masked    = b[7];
        frame_len = '0;
        if (len7 == LEN_CODE_16) begin
          ext_left = 3'd1;
          ph = EXT_LEN;
        end else if (len7 == LEN_CODE_64) begin
          ext_left = 3'd7;
          ph = EXT_LEN;
        end else begin
          frame_len = {57'd0, len7};
          length_known();
        end
      end
      EXT_LEN: begin
        // big-endian, taken as sent even when non-minimal or top bit set
        frame_len = {frame_len[LEN_W-9:0], b};
        if (ext_left == 3'd0) length_known();
        else ext_left = ext_left - 3'd1;
      end
      MASK_KEY: begin
        key = {key[KEY_W-9:0], b};
        if (ext_left == 3'd0) header_complete();
        else ext_left = ext_left - 3'd1;
      end
      PAYLOAD: begin
        // limit is read live for each payload byte
        idx     = pay_idx;
        keep    = idx < {48'd0, max_pay};
        pay_idx = idx + 64'd1;
        last    = (pay_idx == frame_len);
        val     = 8'h00;
        if (keep) begin
          // key byte (index mod 4), first key byte in the top bits
          key_b = 8'(key >> (24 - 8 * idx[1:0]));
          val   = b ^ key_b;
          kept  = kept + 16'd1;
        end
        if (last) ph = WAIT_OPCODE;
        if (keep || last) queue_result(keep, val, last);
      end
      default: ph = WAIT_OPCODE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    logic [7:0] junk;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      junk = 8'($urandom);
      s_tvalid <= 1'b0;
      s_tdata  <= junk;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b);
    n_bytes++;
    @(negedge clk);
  endtask

  // drop valid, let every expected item come out, then give drained bytes time to pass
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_max_payload(input logic [COUNT_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_pay = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame; n_pay payload bytes are actually sent (normally equal to len)
  task automatic send_frame(input logic [3:0] op, input bit mask_on, input len_enc_t enc,
                            input logic [LEN_W-1:0] len, input int unsigned n_pay);
    logic [KEY_W-1:0] mkey;
    logic [3:0]       flags;
    logic [6:0]       len7;
    logic [7:0]       pb;
    mkey  = $urandom;
    flags = 4'($urandom);
    send_byte({flags, op});
    case (enc)
      LEN_SHORT: len7 = len[6:0];
      LEN_EXT16: len7 = LEN_CODE_16;
      default:   len7 = LEN_CODE_64;
    endcase
    send_byte({mask_on, len7});
    if (enc == LEN_EXT16) begin
      for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    end else if (enc == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (mask_on) begin
      for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8]);
    end
    for (int unsigned k = 0; k < n_pay; k++) begin
      pb = 8'($urandom);
      send_byte(pb);
    end
    n_frames++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset limit of 1024: all three length forms, masked and not, empty frames
  task automatic test_header_forms();
    send_frame(OP_TEXT,   1'b0, LEN_SHORT, 64'd5,   5);
    send_frame(OP_BINARY, 1'b1, LEN_SHORT, 64'd9,   9);   // key index wraps twice
    send_frame(OP_PING,   1'b0, LEN_SHORT, 64'd0,   0);   // ends on the length byte
    send_frame(OP_PONG,   1'b1, LEN_SHORT, 64'd0,   0);   // ends on the last key byte
    send_frame(OP_CLOSE,  1'b0, LEN_EXT16, 64'd0,   0);   // ends on last 16-bit length byte
    send_frame(OP_CONT,   1'b1, LEN_EXT64, 64'd0,   0);
    send_frame(OP_BINARY, 1'b1, LEN_SHORT, 64'd125, 125); // longest short length
    send_frame(OP_TEXT,   1'b0, LEN_EXT16, 64'd3,   3);   // non-minimal 16-bit
    send_frame(OP_BINARY, 1'b1, LEN_EXT64, 64'd2,   2);   // non-minimal 64-bit
  endtask

  task automatic test_every_opcode();
    int unsigned n;
    for (int op = 0; op < 16; op++) begin
      n = $urandom_range(0, 1);
      send_frame(op[3:0], 1'($urandom_range(0, 1)), LEN_SHORT, 64'(n), n);
    end
  endtask

  // limit 0: payload fully drained, only the closing item comes out
  task automatic test_no_payload_kept();
    set_max_payload(16'd0);
    send_frame(OP_TEXT,   1'b0, LEN_SHORT, 64'd1, 1);
    send_frame(OP_BINARY, 1'b1, LEN_SHORT, 64'd7, 7);
    send_frame(OP_CLOSE,  1'b1, LEN_SHORT, 64'd0, 0);
  endtask

  // limit 3: frames just under, at and past the limit
  task automatic test_payload_limit_edges();
    set_max_payload(16'd3);
    send_frame(OP_TEXT,   1'b1, LEN_SHORT, 64'd2,  2);
    send_frame(OP_BINARY, 1'b0, LEN_SHORT, 64'd3,  3);
    send_frame(OP_BINARY, 1'b1, LEN_SHORT, 64'd4,  4);
    send_frame(OP_TEXT,   1'b1, LEN_EXT16, 64'd10, 10);
  endtask

  // shortest minimal 16-bit length and a non-minimal 64-bit length under the widest limit
  task automatic test_widest_limit();
    set_max_payload(16'hFFFF);
    send_frame(OP_BINARY, 1'b1, LEN_EXT16, 64'd126, 126);
    send_frame(OP_PING,   1'b0, LEN_EXT64, 64'd1,   1);
  endtask

  // receiver holds off while a frame streams in, so the block stalls its input
  task automatic test_result_backpressure();
    set_max_payload(MAX_PAYLOAD_RST);
    hold_req = 80;
    send_frame(OP_BINARY, 1'b1, LEN_SHORT, 64'd20, 20);
  endtask

  task automatic test_random_frames();
    int          target;
    int unsigned len;
    int unsigned sel;
    len_enc_t    enc;
    logic [COUNT_W-1:0] lim;
    target = n_bytes + 80;
    while (n_bytes < target) begin
      // last stretch runs without any idling
      if (n_bytes + 40 >= target) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        sel = $urandom_range(0, 7);
        if (sel == 0) lim = 16'd0;
        else if (sel == 1) lim = 16'hFFFF;
        else if (sel == 2) lim = MAX_PAYLOAD_RST;
        else lim = 16'($urandom_range(1, 24));
        set_max_payload(lim);
      end
      // mostly short frames, a few with extended lengths
      sel = $urandom_range(0, 19);
      if (sel < 15) len = $urandom_range(0, 20);
      else if (sel < 19) len = $urandom_range(21, 125);
      else len = $urandom_range(126, 200);
      if (len > 125) begin
        if ($urandom_range(0, 1) == 0) enc = LEN_EXT16;
        else enc = LEN_EXT64;
      end else begin
        sel = $urandom_range(0, 5);
        if (sel == 0) enc = LEN_EXT16;
        else if (sel == 1) enc = LEN_EXT64;
        else enc = LEN_SHORT;
      end
      send_frame(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), enc, 64'(len), len);
    end
  endtask

  // 64-bit length with its top bit set: taken as is, the frame never closes, so it runs last
  task automatic test_oversized_length();
    set_max_payload(16'd16);
    send_frame(OP_TEXT, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0040, 20);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random short stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error at item %0d: %s got 0x%0h, expected 0x%0h", n_results, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("item with nothing expected, tdata", m_tdata, 32'd0);
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tuser !== exp_r.has_byte)
          report_mismatch("has_byte", 32'(m_tuser), 32'(exp_r.has_byte));
        if (m_tdata[7:0] !== exp_r.payload_byte)
          report_mismatch("payload_byte", 32'(m_tdata[7:0]), 32'(exp_r.payload_byte));
        if (m_tlast !== exp_r.frame_end)
          report_mismatch("frame_end", 32'(m_tlast), 32'(exp_r.frame_end));
        if (m_tdata[11:8] !== exp_r.frame_opcode)
          report_mismatch("frame_opcode", 32'(m_tdata[11:8]), 32'(exp_r.frame_opcode));
        if (m_tdata[27:12] !== exp_r.kept_count)
          report_mismatch("kept_count", 32'(m_tdata[27:12]), 32'(exp_r.kept_count));
      end
      n_results++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycle_count,
               expected_results.size());
      $display("websocket_frame_deframer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_header_forms();
    test_every_opcode();
    test_no_payload_kept();
    test_payload_limit_edges();
    test_widest_limit();
    test_result_backpressure();
    test_random_frames();
    test_oversized_length();

    wait_idle();
    $display("sent %0d bytes in %0d frames over %0d limit settings; checked %0d items",
             n_bytes, n_frames, n_cfg, n_results);
    if (errors == 0) begin
      $display("websocket_frame_deframer: match");
    end else begin
      $display("%0d field errors", errors);
      $display("websocket_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wsd_pkg.sv
rtl/wsd_parse.sv
rtl/wsd_out_reg.sv
rtl/websocket_frame_deframer.sv
dv/tb_websocket_frame_deframer.sv
